[sv/mcsw_pkg.sv]
package mcsw_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int MASK_BITS    = 4;
    localparam int WALK_N       = (NUM_CHANNELS < MASK_BITS) ? NUM_CHANNELS : MASK_BITS;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [MASK_BITS-1:0] WALK_MASK = MASK_BITS'((1 << WALK_N) - 1);

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [7:0] STALL_LIMIT_RESET = 8'd8;
    localparam logic [7:0] NEVER_LIMIT_RESET = 8'd40;
    localparam logic [MASK_BITS-1:0] ENABLE_MASK_RESET = MASK_BITS'(3);

    localparam logic [1:0] REQ_PROGRESS  = 2'd0;
    localparam logic [1:0] REQ_HEARTBEAT = 2'd1;
    localparam logic [1:0] REQ_TICK      = 2'd2;

    localparam logic [1:0] REPORT_NONE    = 2'd0;
    localparam logic [1:0] REPORT_STALLED = 2'd1;
    localparam logic [1:0] REPORT_NEVER   = 2'd2;
    localparam logic [1:0] REPORT_RESUMED = 2'd3;

    localparam logic [1:0] CFG_STALL_LIMIT = 2'd0;
    localparam logic [1:0] CFG_NEVER_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ENABLE_MASK = 2'd2;

    typedef enum logic [1:0] {
        CMD_PROGRESS  = 2'd0,
        CMD_HEARTBEAT = 2'd1,
        CMD_TICK      = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [1:0] chan;
    } cmd_t;

    typedef struct packed {
        logic                 valid;
        cmd_t                 cmd;
    } queue_head_t;

    typedef struct packed {
        logic [7:0]           stall_limit;
        logic [7:0]           never_limit;
        logic [MASK_BITS-1:0] enable_mask;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } back_state_t;

endpackage

[sv/multi_channel_stall_watchdog_top.sv]
// a tick is queued, taken from the queue by the back end in its idle state, and then the
// walk visits the channels in order, disabled ones giving no result; each result is registered
// progress and heartbeat are handled in the idle state as they are dequeued; a tick walks every
// channel before the next request is dequeued, and the walk stalls while a result waits
// reset: synchronous, active low; clears all channel state and heartbeat count,
// sets the limits to 8 and 40 seconds and the enable mask to 3
module multi_channel_stall_watchdog_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic [7:0]  s_tdata,   // [1:0] channel_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [1:0] report_channel, [9:2] elapsed_seconds,
                                   // [41:10] heartbeats_last_second
    output logic [1:0]  m_tuser,   // [1:0] report_kind
    output logic        m_tlast,   // last_of_tick
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    mcsw_pkg::cfg_t        cfg_reg, cfg_next;
    mcsw_pkg::queue_head_t head;
    logic                  pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mcsw_pkg::CFG_STALL_LIMIT: cfg_next.stall_limit = cfg_data;
                mcsw_pkg::CFG_NEVER_LIMIT: cfg_next.never_limit = cfg_data;
                mcsw_pkg::CFG_ENABLE_MASK: begin
                    cfg_next.enable_mask = cfg_data[mcsw_pkg::MASK_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stall_limit <= mcsw_pkg::STALL_LIMIT_RESET;
            cfg_reg.never_limit <= mcsw_pkg::NEVER_LIMIT_RESET;
            cfg_reg.enable_mask <= mcsw_pkg::ENABLE_MASK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mcsw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    mcsw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[sv/mcsw_front.sv]
module mcsw_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,  // [1:0] req_type
    input  logic [7:0]           s_tdata,  // [1:0] channel_index
    output mcsw_pkg::queue_head_t head,
    input  logic                 pop
);

    mcsw_pkg::cmd_t queue_reg [mcsw_pkg::QDEPTH];
    logic [mcsw_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mcsw_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mcsw_pkg::QCNT_W-1:0] count_reg, count_next;
    logic       keep;
    logic       push;
    mcsw_pkg::cmd_t cmd;

    // classify: unused requests and out-of-range progress are dropped here
    always_comb begin
        keep     = 1'b0;
        cmd.kind = mcsw_pkg::CMD_PROGRESS;
        cmd.chan = s_tdata[1:0];
        case (s_tuser)
            mcsw_pkg::REQ_PROGRESS: begin
                keep     = (32'(s_tdata[1:0]) < mcsw_pkg::NUM_CHANNELS);
                cmd.kind = mcsw_pkg::CMD_PROGRESS;
            end
            mcsw_pkg::REQ_HEARTBEAT: begin
                keep     = 1'b1;
                cmd.kind = mcsw_pkg::CMD_HEARTBEAT;
            end
            mcsw_pkg::REQ_TICK: begin
                keep     = 1'b1;
                cmd.kind = mcsw_pkg::CMD_TICK;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready  = (count_reg != mcsw_pkg::QCNT_W'(mcsw_pkg::QDEPTH));
    assign push      = s_tvalid && s_tready && keep;
    assign head.valid = (count_reg != '0);
    assign head.cmd  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

[sv/mcsw_back.sv]
module mcsw_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mcsw_pkg::cfg_t        cfg,
    input  mcsw_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,  // [1:0] report_channel, [9:2] elapsed_seconds,
                                            // [41:10] heartbeats_last_second
    output logic [1:0]            m_tuser,  // [1:0] report_kind
    output logic                  m_tlast   // last_of_tick
);

    localparam int NC = mcsw_pkg::NUM_CHANNELS;
    localparam int CW = mcsw_pkg::CH_IDX_W;

    mcsw_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic [NC-1:0] prog_reg, prog_next;
    logic [NC-1:0] started_reg, started_next;
    logic [NC-1:0] stall_rep_reg, stall_rep_next;
    logic [NC-1:0] never_rep_reg, never_rep_next;
    logic [7:0]    quiet_reg [NC];
    logic [7:0]    quiet_next [NC];
    logic [7:0]    dead_reg [NC];
    logic [7:0]    dead_next [NC];
    logic [31:0]   hb_reg, hb_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic [1:0]    out_chan_reg, out_chan_next;
    logic [7:0]    out_elapsed_reg, out_elapsed_next;
    logic [31:0]   out_hb_reg, out_hb_next;
    logic          out_last_reg, out_last_next;

    logic [mcsw_pkg::MASK_BITS-1:0] walk_mask;
    logic [mcsw_pkg::MASK_BITS-1:0] mask_sh;
    logic          en;
    logic          out_free;
    logic          step;
    logic [7:0]    q_cur, d_cur, q_inc, d_inc;
    logic [CW-1:0] prog_idx;

    assign walk_mask = cfg.enable_mask & mcsw_pkg::WALK_MASK;
    assign mask_sh   = walk_mask >> walk_reg;
    assign en        = mask_sh[0];
    assign out_free  = !out_valid_reg || m_tready;
    assign step      = (state_reg == mcsw_pkg::ST_WALK) && (!en || out_free);
    assign pop       = (state_reg == mcsw_pkg::ST_IDLE) && head.valid;
    assign prog_idx  = CW'(head.cmd.chan);

    assign q_cur = quiet_reg[walk_reg];
    assign d_cur = dead_reg[walk_reg];
    assign q_inc = (q_cur == 8'hFF) ? q_cur : q_cur + 8'd1;
    assign d_inc = (d_cur == 8'hFF) ? d_cur : d_cur + 8'd1;

    always_comb begin
        state_next       = state_reg;
        walk_next        = walk_reg;
        prog_next        = prog_reg;
        started_next     = started_reg;
        stall_rep_next   = stall_rep_reg;
        never_rep_next   = never_rep_reg;
        quiet_next       = quiet_reg;
        dead_next        = dead_reg;
        hb_next          = hb_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_kind_next    = out_kind_reg;
        out_chan_next    = out_chan_reg;
        out_elapsed_next = out_elapsed_reg;
        out_hb_next      = out_hb_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            mcsw_pkg::ST_IDLE: begin
                if (head.valid) begin
                    case (head.cmd.kind)
                        mcsw_pkg::CMD_PROGRESS: begin
                            prog_next[prog_idx]    = 1'b1;
                            started_next[prog_idx] = 1'b1;
                        end
                        mcsw_pkg::CMD_HEARTBEAT: begin
                            if (hb_reg != 32'hFFFF_FFFF) begin
                                hb_next = hb_reg + 32'd1;
                            end
                        end
                        mcsw_pkg::CMD_TICK: begin
                            state_next = mcsw_pkg::ST_WALK;
                            walk_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mcsw_pkg::ST_WALK: begin
                if (step) begin
                    if (en) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = mcsw_pkg::REPORT_NONE;
                        out_chan_next  = 2'(walk_reg);
                        out_hb_next    = hb_reg;
                        out_last_next  = ((mask_sh >> 1) == '0);
                        if (prog_reg[walk_reg]) begin
                            out_elapsed_next = q_cur;
                            if (stall_rep_reg[walk_reg]) begin
                                out_kind_next = mcsw_pkg::REPORT_RESUMED;
                            end
                            quiet_next[walk_reg]     = 8'd0;
                            stall_rep_next[walk_reg] = 1'b0;
                            prog_next[walk_reg]      = 1'b0;
                        end else if (!started_reg[walk_reg]) begin
                            out_elapsed_next = d_cur;
                            if (!never_rep_reg[walk_reg]) begin
                                dead_next[walk_reg] = d_inc;
                                out_elapsed_next    = d_inc;
                                if (d_inc >= cfg.never_limit) begin
                                    never_rep_next[walk_reg] = 1'b1;
                                    out_kind_next = mcsw_pkg::REPORT_NEVER;
                                end
                            end
                        end else begin
                            out_elapsed_next = q_cur;
                            if (!stall_rep_reg[walk_reg]) begin
                                quiet_next[walk_reg] = q_inc;
                                out_elapsed_next     = q_inc;
                                if (q_inc >= cfg.stall_limit) begin
                                    stall_rep_next[walk_reg] = 1'b1;
                                    out_kind_next = mcsw_pkg::REPORT_STALLED;
                                end
                            end
                        end
                    end
                    if (walk_reg == CW'(mcsw_pkg::WALK_N - 1)) begin
                        state_next = mcsw_pkg::ST_IDLE;
                        hb_next    = '0;
                    end else begin
                        walk_next = walk_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = mcsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mcsw_pkg::ST_IDLE;
            walk_reg      <= '0;
            prog_reg      <= '0;
            started_reg   <= '0;
            stall_rep_reg <= '0;
            never_rep_reg <= '0;
            hb_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NC; i++) begin
                quiet_reg[i] <= 8'd0;
                dead_reg[i]  <= 8'd0;
            end
        end else begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            prog_reg      <= prog_next;
            started_reg   <= started_next;
            stall_rep_reg <= stall_rep_next;
            never_rep_reg <= never_rep_next;
            hb_reg        <= hb_next;
            out_valid_reg <= out_valid_next;
            quiet_reg     <= quiet_next;
            dead_reg      <= dead_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg    <= out_kind_next;
        out_chan_reg    <= out_chan_next;
        out_elapsed_reg <= out_elapsed_next;
        out_hb_reg      <= out_hb_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_hb_reg, out_elapsed_reg, out_chan_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

[sim/multi_channel_stall_watchdog_top_tb.sv]
`timescale 1ns / 1ps

module multi_channel_stall_watchdog_top_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  chan;
        logic [7:0]  elapsed;
        logic [31:0] beats;
        logic        last;
    } report_t;

    typedef struct {
        int          phase;
        logic [1:0]  req;
        logic [1:0]  chan;
        bit          typed;
        logic [1:0]  kind;
        logic [7:0]  elapsed;
        logic [31:0] beats;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = mcsw_pkg::REQ_PROGRESS;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = mcsw_pkg::CFG_STALL_LIMIT;
    logic [7:0]  cfg_data = 8'd0;

    // watchdog state as the block should hold it
    logic [7:0]                     stall_lim = mcsw_pkg::STALL_LIMIT_RESET;
    logic [7:0]                     never_lim = mcsw_pkg::NEVER_LIMIT_RESET;
    logic [mcsw_pkg::MASK_BITS-1:0] chan_mask = mcsw_pkg::ENABLE_MASK_RESET;
    logic       prog_flag [mcsw_pkg::NUM_CHANNELS] = '{default: 1'b0};
    logic       started   [mcsw_pkg::NUM_CHANNELS] = '{default: 1'b0};
    logic [7:0] quiet     [mcsw_pkg::NUM_CHANNELS] = '{default: 8'd0};
    logic       stall_rep [mcsw_pkg::NUM_CHANNELS] = '{default: 1'b0};
    logic [7:0] dead      [mcsw_pkg::NUM_CHANNELS] = '{default: 8'd0};
    logic       never_rep [mcsw_pkg::NUM_CHANNELS] = '{default: 1'b0};
    logic [31:0] beat_count = 32'd0;

    report_t due_reports [$];
    int      error_count = 0;
    int      reports_checked = 0;
    int      requests_sent = 0;
    int      settings_loaded = 0;
    int      gap_max = 6;
    int      hold_left = 0;

    mcsw_pkg::cfg_t phase_cfg [4] = '{
        '{stall_limit: mcsw_pkg::STALL_LIMIT_RESET, never_limit: mcsw_pkg::NEVER_LIMIT_RESET,
          enable_mask: mcsw_pkg::ENABLE_MASK_RESET},
        '{stall_limit: 8'd0,   never_limit: 8'd1,   enable_mask: 4'hF},
        '{stall_limit: 8'd255, never_limit: 8'd255, enable_mask: 4'h0},
        '{stall_limit: 8'd1,   never_limit: 8'd2,   enable_mask: 4'b0100}
    };

    stim_row_t directed_rows [24] = '{
        '{0, mcsw_pkg::REQ_TICK,      2'd0, 1, mcsw_pkg::REPORT_NONE, 8'd1, 32'd0},
        '{0, mcsw_pkg::REQ_HEARTBEAT, 2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{0, mcsw_pkg::REQ_HEARTBEAT, 2'd1, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{0, REQ_UNUSED,              2'd3, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{0, mcsw_pkg::REQ_TICK,      2'd0, 1, mcsw_pkg::REPORT_NONE, 8'd2, 32'd2},
        '{0, mcsw_pkg::REQ_PROGRESS,  2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{0, mcsw_pkg::REQ_PROGRESS,  2'd3, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{0, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{0, mcsw_pkg::REQ_HEARTBEAT, 2'd2, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{0, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{1, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{1, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{1, mcsw_pkg::REQ_PROGRESS,  2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{1, mcsw_pkg::REQ_PROGRESS,  2'd1, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{1, mcsw_pkg::REQ_HEARTBEAT, 2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{1, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{1, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{2, mcsw_pkg::REQ_HEARTBEAT, 2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{2, mcsw_pkg::REQ_HEARTBEAT, 2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{2, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{2, mcsw_pkg::REQ_PROGRESS,  2'd2, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{2, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{3, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0},
        '{3, mcsw_pkg::REQ_TICK,      2'd0, 0, mcsw_pkg::REPORT_NONE, 8'd0, 32'd0}
    };

    multi_channel_stall_watchdog_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic advance_watchdog(input logic [1:0] req, input logic [1:0] ch,
                                    input bit typed, input logic [1:0] t_kind,
                                    input logic [7:0] t_elapsed, input logic [31:0] t_beats);
        report_t    r;
        logic [1:0] kind;
        logic [7:0] el;
        int         top;
        top = -1;
        case (req)
            mcsw_pkg::REQ_PROGRESS: begin
                if (int'(ch) < mcsw_pkg::NUM_CHANNELS) begin
                    prog_flag[ch] = 1'b1;
                    started[ch] = 1'b1;
                end
            end
            mcsw_pkg::REQ_HEARTBEAT: begin
                if (beat_count != 32'hFFFF_FFFF)
                    beat_count = beat_count + 32'd1;
            end
            mcsw_pkg::REQ_TICK: begin
                for (int c = 0; c < mcsw_pkg::WALK_N; c++)
                    if (chan_mask[c])
                        top = c;
                for (int c = 0; c < mcsw_pkg::WALK_N; c++) begin
                    if (chan_mask[c]) begin
                        kind = mcsw_pkg::REPORT_NONE;
                        if (prog_flag[c]) begin
                            el = quiet[c];
                            if (stall_rep[c])
                                kind = mcsw_pkg::REPORT_RESUMED;
                            quiet[c] = 8'd0;
                            stall_rep[c] = 1'b0;
                            prog_flag[c] = 1'b0;
                        end else if (!started[c]) begin
                            if (!never_rep[c]) begin
                                if (dead[c] != 8'hFF)
                                    dead[c] = dead[c] + 8'd1;
                                if (dead[c] >= never_lim) begin
                                    never_rep[c] = 1'b1;
                                    kind = mcsw_pkg::REPORT_NEVER;
                                end
                            end
                            el = dead[c];
                        end else begin
                            if (!stall_rep[c]) begin
                                if (quiet[c] != 8'hFF)
                                    quiet[c] = quiet[c] + 8'd1;
                                if (quiet[c] >= stall_lim) begin
                                    stall_rep[c] = 1'b1;
                                    kind = mcsw_pkg::REPORT_STALLED;
                                end
                            end
                            el = quiet[c];
                        end
                        r.kind    = typed ? t_kind : kind;
                        r.chan    = c[1:0];
                        r.elapsed = typed ? t_elapsed : el;
                        r.beats   = typed ? t_beats : beat_count;
                        r.last    = (c == top);
                        due_reports.insert(due_reports.size(), r);
                    end
                end
                beat_count = 32'd0;
            end
            default: ;
        endcase
    endtask

    task automatic send_req(input logic [1:0] req, input logic [1:0] ch,
                            input bit typed = 0,
                            input logic [1:0] t_kind = mcsw_pkg::REPORT_NONE,
                            input logic [7:0] t_elapsed = 8'd0,
                            input logic [31:0] t_beats = 32'd0);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'd0, ch};
        do @(posedge aclk); while (!s_tready);
        advance_watchdog(req, ch, typed, t_kind, t_elapsed, t_beats);
        requests_sent++;
    endtask

    // stop offering, let every report and any queued request drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic next_phase(input mcsw_pkg::cfg_t cfg);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        idx[0] = mcsw_pkg::CFG_STALL_LIMIT;
        idx[1] = mcsw_pkg::CFG_NEVER_LIMIT;
        idx[2] = mcsw_pkg::CFG_ENABLE_MASK;
        val[0] = cfg.stall_limit;
        val[1] = cfg.never_limit;
        val[2] = 8'(cfg.enable_mask);
        settle();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        stall_lim = cfg.stall_limit;
        never_lim = cfg.never_limit;
        chan_mask = cfg.enable_mask;
        settings_loaded++;
    endtask

    task automatic send_random_mix(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_req(mcsw_pkg::REQ_PROGRESS, 2'($urandom_range(0, 3)));
            else if (pick < 60)
                send_req(mcsw_pkg::REQ_HEARTBEAT, 2'($urandom_range(0, 3)));
            else if (pick < 95)
                send_req(mcsw_pkg::REQ_TICK, 2'($urandom_range(0, 3)));
            else
                send_req(REQ_UNUSED, 2'($urandom_range(0, 3)));
        end
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // result side
    initial begin
        int      idle_left;
        report_t want;
        idle_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (due_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none, got kind %0d channel %0d",
                             $time, m_tuser, m_tdata[1:0]);
                    error_count++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("report_kind", want.kind, m_tuser);
                    check_field("report_channel", want.chan, m_tdata[1:0]);
                    check_field("elapsed_seconds", want.elapsed, m_tdata[9:2]);
                    check_field("heartbeats_last_second", want.beats, m_tdata[41:10]);
                    check_field("last_of_tick", want.last, m_tlast);
                    reports_checked++;
                end
                idle_left = $urandom_range(0, gap_max);
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                m_tready <= 1'b0;
                idle_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int             cur_phase;
        int             pick;
        mcsw_pkg::cfg_t cfg;
        cur_phase = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].phase != cur_phase) begin
                cur_phase = directed_rows[i].phase;
                next_phase(phase_cfg[cur_phase]);
            end
            send_req(directed_rows[i].req, directed_rows[i].chan, directed_rows[i].typed,
                     directed_rows[i].kind, directed_rows[i].elapsed, directed_rows[i].beats);
        end

        // receiver holds off while requests keep coming
        cfg.stall_limit = 8'($urandom_range(1, 6));
        cfg.never_limit = 8'($urandom_range(1, 12));
        cfg.enable_mask = 4'hF;
        next_phase(cfg);
        hold_left = 80;
        send_random_mix(70);

        // back to back on both sides
        gap_max = 0;
        cfg.stall_limit = 8'd2;
        cfg.never_limit = 8'd0;
        cfg.enable_mask = 4'($urandom_range(0, 15));
        next_phase(cfg);
        send_random_mix(50);

        // one channel left quiet for a long run of ticks
        gap_max = 2;
        cfg.stall_limit = 8'd255;
        cfg.never_limit = 8'd255;
        cfg.enable_mask = 4'b0001;
        next_phase(cfg);
        send_req(mcsw_pkg::REQ_PROGRESS, 2'd0);
        for (int i = 0; i < 115; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_req(mcsw_pkg::REQ_HEARTBEAT, 2'($urandom_range(0, 3)));
            else if (pick < 12)
                send_req(mcsw_pkg::REQ_PROGRESS, 2'($urandom_range(1, 3)));
            else
                send_req(mcsw_pkg::REQ_TICK, 2'($urandom_range(0, 3)));
        end

        settle();
        $display("Sent %0d requests and checked %0d reports under %0d register settings",
                 requests_sent, reports_checked, settings_loaded + 1);
        $display("Covered limits of 0, 1 and 255, empty and full enable masks, and a long stall");
        if (error_count == 0 && due_reports.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timed out with %0d reports outstanding", $time, due_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
